// ===== src/ssoc_pkg.sv =====
`default_nettype none
package ssoc_pkg;

    localparam int W_SAMPLE  = 16;
    localparam int W_CNT     = 14;
    localparam int W_TOTAL   = 16;
    localparam int W_SUM     = 31;
    localparam int W_THR     = 16;
    localparam int W_GRAV    = 15;
    localparam int W_OFF     = 21;
    localparam int W_STATUS  = 3;
    localparam int W_PROD    = 32;
    localparam int W_NUM     = 36;
    localparam int DIV_STEPS = W_NUM;
    localparam int W_DCNT    = $clog2(DIV_STEPS + 1);
    localparam int N_AXES    = 3;
    localparam int W_AXIS    = $clog2(N_AXES);

    localparam int RETRY_FACTOR = 3;

    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 16;

    localparam logic [W_CFG_IDX-1:0] CFG_TARGET    = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_MIN_VALID = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_THRESHOLD = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_AXIS_MODE = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_GRAVITY   = 3'd4;

    localparam logic [W_CFG_IDX-1:0] CMD_SAMPLE = 3'd0;

    localparam logic [W_STATUS-1:0] ST_COLLECT   = 3'd0;
    localparam logic [W_STATUS-1:0] ST_MOTION    = 3'd1;
    localparam logic [W_STATUS-1:0] ST_OK        = 3'd2;
    localparam logic [W_STATUS-1:0] ST_NOT_STILL = 3'd3;
    localparam logic [W_STATUS-1:0] ST_PARAM     = 3'd4;
    localparam logic [W_STATUS-1:0] ST_IDLE      = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIM,
        S_MUL,
        S_CMP,
        S_UPD,
        S_GMUL,
        S_DLOAD,
        S_DWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [W_NUM-1:0] dividend;
        logic [W_CNT-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [W_OFF-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== src/ssoc_mul.sv =====
`default_nettype none
module ssoc_mul
    import ssoc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [W_SAMPLE:0]    i_a,
    input  wire logic signed [W_CNT:0]       i_b,
    output logic signed [W_PROD-1:0]         o_prod
);

    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_PROD-1:0] n_prod;

    always_comb begin
        n_prod = W_PROD'(i_a * i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== src/ssoc_div.sv =====
`default_nettype none
module ssoc_div
    import ssoc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [W_DCNT-1:0] r_cnt;
    logic [W_CNT-1:0]  r_rem;
    logic [W_NUM-1:0]  r_quo;
    logic [W_CNT-1:0]  r_div;

    logic [W_CNT:0]    n_shift;
    logic [W_CNT:0]    n_diff;
    logic              n_ge;

    // one restoring step: bring down the next dividend bit
    always_comb begin
        n_shift = {r_rem, r_quo[W_NUM-1]};
        n_diff  = n_shift - {1'b0, r_div};
        n_ge    = (n_shift >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= W_DCNT'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == W_DCNT'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[W_CNT-1:0] : n_shift[W_CNT-1:0];
            r_quo <= {r_quo[W_NUM-2:0], n_ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[W_OFF-1:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding step");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for two cycles");

endmodule
`default_nettype wire

// ===== src/still_sample_offset_calibrator.sv =====
`default_nettype none
// Channel    Direction  Handshake                  Payload
// input      in         i_in_valid / o_in_stall    i_cmd, i_sample_x/y/z
// result     out        o_out_valid / i_out_stall  o_status, o_offset_x/y/z,
//                                                  o_accepted_count
// config     in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A sample during a run, but the first of a run, sends three products s*n and one
// threshold product through a single 17x15 multiplier; each s*n is compared in S_CMP.
// Reporting offsets for a non-empty run adds three 36-step restoring divisions,
// one quotient bit per cycle, in the one shared divider.
// A new transaction is taken while the previous result still waits in the output
// register; it is held in the output state until that result is taken.
// Synchronous active-low reset; no clearing pass is needed.
module still_sample_offset_calibrator
    import ssoc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_cmd,
    input  wire logic signed [W_SAMPLE-1:0]  i_sample_x,
    input  wire logic signed [W_SAMPLE-1:0]  i_sample_y,
    input  wire logic signed [W_SAMPLE-1:0]  i_sample_z,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [W_STATUS-1:0]              o_status,
    output logic signed [W_OFF-1:0]          o_offset_x,
    output logic signed [W_OFF-1:0]          o_offset_y,
    output logic signed [W_OFF-1:0]          o_offset_z,
    output logic [W_CNT-1:0]                 o_accepted_count,
    input  wire logic                        i_cfg_we,
    input  wire logic [W_CFG_IDX-1:0]        i_cfg_index,
    input  wire logic [W_CFG_DATA-1:0]       i_cfg_data
);

    // configuration
    logic [W_CNT-1:0]  r_target;
    logic [W_CNT-1:0]  r_min_valid;
    logic [W_THR-1:0]  r_thr;
    logic              r_accel;
    logic [W_GRAV-1:0] r_grav;

    // run state
    t_state                   r_state;
    t_state                   n_state;
    logic                     r_run;
    logic [W_TOTAL-1:0]       r_total;
    logic [W_CNT-1:0]         r_valid;
    logic signed [W_SUM-1:0]  r_sum [N_AXES];
    logic [W_STATUS-1:0]      r_final;

    // per-transaction working registers
    logic signed [W_SAMPLE-1:0] r_s [N_AXES];
    logic [W_AXIS-1:0]          r_idx;
    logic                       r_first;
    logic                       r_moved;
    logic [W_PROD-1:0]          r_lim;
    logic                       r_neg;
    logic [W_STATUS-1:0]        r_status;
    logic signed [W_OFF-1:0]    r_off [N_AXES];

    // output register
    logic                       r_out_valid;
    logic [W_STATUS-1:0]        r_out_status;
    logic signed [W_OFF-1:0]    r_out_off [N_AXES];
    logic [W_CNT-1:0]           r_out_cnt;

    // shared units
    logic                       mul_en;
    logic signed [W_SAMPLE:0]   mul_a;
    logic signed [W_CNT:0]      mul_b;
    logic signed [W_PROD-1:0]   mul_prod;
    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    logic                       in_acc;
    logic                       out_free;
    logic [W_STATUS-1:0]        cmd_status;
    logic                       cmd_run;
    logic [W_STATUS-1:0]        idle_status;
    logic [W_CNT-1:0]           upd_valid;
    logic                       upd_fin;
    logic [W_STATUS-1:0]        upd_status;
    logic [W_TOTAL-1:0]         total_limit;
    logic signed [W_PROD:0]     cmp_diff;
    logic [W_PROD:0]            cmp_mag;
    logic signed [W_NUM-1:0]    num;
    logic [W_NUM-1:0]           num_mag;
    logic                       z_grav;

    ssoc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    ssoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // start command outcome
    always_comb begin
        cmd_run    = 1'b0;
        cmd_status = ST_PARAM;
        if (r_target >= r_min_valid) begin
            if (r_target == '0) begin
                cmd_status = (r_min_valid != '0) ? ST_NOT_STILL : ST_OK;
            end else begin
                cmd_run    = 1'b1;
                cmd_status = ST_COLLECT;
            end
        end
        idle_status = i_cmd ? cmd_status : r_final;
    end

    // count update and end-of-run test
    always_comb begin
        total_limit = W_TOTAL'(r_target) * W_TOTAL'(RETRY_FACTOR);
        if (r_first) begin
            upd_valid = W_CNT'(1);
        end else if (r_moved) begin
            upd_valid = '0;
        end else begin
            upd_valid = r_valid + 1'b1;
        end
        upd_fin    = (r_total >= total_limit) || (upd_valid >= r_target);
        upd_status = r_moved ? ST_MOTION : ST_COLLECT;
        if (upd_fin) begin
            upd_status = (upd_valid < r_min_valid) ? ST_NOT_STILL : ST_OK;
        end
    end

    // |s*n - sum| against threshold*n
    always_comb begin
        cmp_diff = (W_PROD+1)'(mul_prod) - (W_PROD+1)'(r_sum[r_idx]);
        cmp_mag  = cmp_diff[W_PROD] ? (W_PROD+1)'(-cmp_diff) : cmp_diff;
    end

    // numerator of the mean, in sixteenths
    always_comb begin
        z_grav  = r_accel && (r_idx == W_AXIS'(N_AXES - 1));
        num     = W_NUM'(r_sum[r_idx]) <<< 4;
        if (z_grav) begin
            num = num - (W_NUM'(mul_prod) <<< 4);
        end
        num_mag = num[W_NUM-1] ? W_NUM'(-num) : num;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd || !r_run) begin
                        n_state = (idle_status == ST_OK) ? S_GMUL : S_OUT;
                    end else if (r_valid == '0) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_LIM;
                    end
                end
            end
            S_LIM:   n_state = S_MUL;
            S_MUL:   n_state = S_CMP;
            S_CMP:   n_state = (r_idx == W_AXIS'(N_AXES - 1)) ? S_UPD : S_MUL;
            S_UPD:   n_state = (upd_status == ST_OK) ? S_GMUL : S_OUT;
            S_GMUL:  n_state = S_DLOAD;
            S_DLOAD: begin
                if (r_valid != '0) begin
                    n_state = S_DWAIT;
                end else if (r_idx == W_AXIS'(N_AXES - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_idx == W_AXIS'(N_AXES - 1)) ? S_OUT : S_DLOAD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // shared unit control
    always_comb begin
        mul_en           = 1'b0;
        mul_a            = '0;
        mul_b            = (W_CNT+1)'(r_valid);
        div_req.start    = 1'b0;
        div_req.dividend = num_mag;
        div_req.divisor  = r_valid;
        case (r_state)
            S_LIM: begin
                mul_en = 1'b1;
                mul_a  = (W_SAMPLE+1)'(r_thr);
            end
            S_MUL: begin
                mul_en = 1'b1;
                mul_a  = (W_SAMPLE+1)'(r_s[r_idx]);
            end
            S_GMUL: begin
                mul_en = 1'b1;
                mul_a  = (W_SAMPLE+1)'(r_grav);
            end
            S_DLOAD: begin
                div_req.start = (r_valid != '0);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= 1'b0;
            r_total     <= '0;
            r_valid     <= '0;
            r_final     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_target    <= W_CNT'(1000);
            r_min_valid <= W_CNT'(100);
            r_thr       <= W_THR'(50);
            r_accel     <= 1'b0;
            r_grav      <= W_GRAV'(2048);
            for (int i = 0; i < N_AXES; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TARGET:    r_target    <= i_cfg_data[W_CNT-1:0];
                    CFG_MIN_VALID: r_min_valid <= i_cfg_data[W_CNT-1:0];
                    CFG_THRESHOLD: r_thr       <= i_cfg_data[W_THR-1:0];
                    CFG_AXIS_MODE: r_accel     <= i_cfg_data[0];
                    CFG_GRAVITY:   r_grav      <= i_cfg_data[W_GRAV-1:0];
                    default:       r_accel     <= r_accel;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_cmd) begin
                            r_total <= '0;
                            r_valid <= '0;
                            for (int i = 0; i < N_AXES; i++) begin
                                r_sum[i] <= '0;
                            end
                            r_run <= cmd_run;
                            if (!cmd_run) begin
                                r_final <= cmd_status;
                            end
                        end else if (r_run) begin
                            r_total <= r_total + 1'b1;
                        end
                    end
                end
                S_UPD: begin
                    r_valid <= upd_valid;
                    for (int i = 0; i < N_AXES; i++) begin
                        if (r_first) begin
                            r_sum[i] <= W_SUM'(r_s[i]);
                        end else if (r_moved) begin
                            r_sum[i] <= '0;
                        end else begin
                            r_sum[i] <= r_sum[i] + W_SUM'(r_s[i]);
                        end
                    end
                    if (upd_fin) begin
                        r_run   <= 1'b0;
                        r_final <= upd_status;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_run <= r_run;
                end
            endcase
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_s[0]   <= i_sample_x;
                    r_s[1]   <= i_sample_y;
                    r_s[2]   <= i_sample_z;
                    r_idx    <= '0;
                    r_moved  <= 1'b0;
                    r_first  <= (r_valid == '0);
                    r_status <= (i_cmd || !r_run) ? idle_status : ST_COLLECT;
                    for (int i = 0; i < N_AXES; i++) begin
                        r_off[i] <= '0;
                    end
                end
            end
            S_MUL: begin
                // the threshold product lands here on the first axis
                if (r_idx == '0) begin
                    r_lim <= mul_prod;
                end
            end
            S_CMP: begin
                if (cmp_mag > {1'b0, r_lim}) begin
                    r_moved <= 1'b1;
                end
                r_idx <= r_idx + 1'b1;
            end
            S_UPD: begin
                r_status <= upd_status;
            end
            S_GMUL: begin
                r_idx <= '0;
            end
            S_DLOAD: begin
                r_neg <= num[W_NUM-1];
                if (r_valid == '0) begin
                    // empty run: mean taken as zero, gravity still removed
                    r_off[r_idx] <= z_grav ? W_OFF'(0) - W_OFF'({r_grav, 4'b0000}) : '0;
                    r_idx        <= r_idx + 1'b1;
                end
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    r_off[r_idx] <= r_neg ? W_OFF'(0) - div_rsp.quotient : div_rsp.quotient;
                    r_idx        <= r_idx + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_cnt    <= r_valid;
                    for (int i = 0; i < N_AXES; i++) begin
                        r_out_off[i] <= r_off[i];
                    end
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_offset_x       = r_out_off[0];
    assign o_offset_y       = r_out_off[1];
    assign o_offset_z       = r_out_off[2];
    assign o_accepted_count = r_out_cnt;

    a_wait_has_divider: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DWAIT) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");

    a_offsets_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        (o_offset_x == '0 && o_offset_y == '0 && o_offset_z == '0))
        else $error("offsets reported without a completed run");

    a_param_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd && (r_target < r_min_valid)) |=> (!r_run && r_final == ST_PARAM))
        else $error("bad target did not close the run");

    a_run_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy with the sequencer idle");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import ssoc_pkg::*;

    localparam logic CMD_START    = 1'b1;
    localparam logic CMD_DATA     = 1'b0;
    localparam int   N_RANDOM     = 750;
    localparam int   HOLD_CYCLES  = 600;
    localparam int   DRAIN_CYCLES = 200;
    localparam int   MAX_SHOWN    = 10;

    typedef struct packed {
        logic                       cmd;
        logic signed [W_SAMPLE-1:0] x;
        logic signed [W_SAMPLE-1:0] y;
        logic signed [W_SAMPLE-1:0] z;
    } t_sample;

    typedef struct packed {
        logic [W_STATUS-1:0]     status;
        logic signed [W_OFF-1:0] off_x;
        logic signed [W_OFF-1:0] off_y;
        logic signed [W_OFF-1:0] off_z;
        logic [W_CNT-1:0]        count;
    } t_report;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_cmd    = 1'b0;
    logic signed [W_SAMPLE-1:0] in_x      = '0;
    logic signed [W_SAMPLE-1:0] in_y      = '0;
    logic signed [W_SAMPLE-1:0] in_z      = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [W_CFG_IDX-1:0]       cfg_index = '0;
    logic [W_CFG_DATA-1:0]      cfg_data  = '0;

    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [W_STATUS-1:0]        o_status;
    logic signed [W_OFF-1:0]    o_offset_x;
    logic signed [W_OFF-1:0]    o_offset_y;
    logic signed [W_OFF-1:0]    o_offset_z;
    logic [W_CNT-1:0]           o_accepted_count;

    still_sample_offset_calibrator u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (in_cmd),
        .i_sample_x       (in_x),
        .i_sample_y       (in_y),
        .i_sample_z       (in_z),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_status         (o_status),
        .o_offset_x       (o_offset_x),
        .o_offset_y       (o_offset_y),
        .o_offset_z       (o_offset_z),
        .o_accepted_count (o_accepted_count),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // Calibrator shadow: registers and run state as after reset
    logic [W_CNT-1:0]    cal_target  = 14'd1000;
    logic [W_CNT-1:0]    cal_min     = 14'd100;
    logic [W_THR-1:0]    cal_thr     = 16'd50;
    logic                cal_accel   = 1'b0;
    logic [W_GRAV-1:0]   cal_grav    = 15'd2048;
    logic                cal_running = 1'b0;
    logic [W_TOTAL-1:0]  cal_total   = '0;
    logic [W_CNT-1:0]    cal_valid   = '0;
    longint              cal_sum [N_AXES];
    logic [W_STATUS-1:0] cal_final   = ST_IDLE;

    t_sample sample_q [$];
    t_report due_reports [$];
    int      n_queued    = 0;
    int      n_bad       = 0;
    int      in_acc_cnt  = 0;
    int      res_cnt     = 0;
    int      hold_req    = 0;
    bit      snd_fast    = 1'b0;
    bit      rcv_fast    = 1'b0;

    // driver and receiver bookkeeping
    t_sample tx_cur      = '0;
    bit      tx_busy     = 1'b0;
    int      tx_seen     = 0;
    int      tx_wait     = 0;
    int      rx_seen     = 0;
    int      rx_hold_seen = 0;
    int      rx_wait     = 0;
    int      rx_hold     = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic void clear_run();
        cal_total = '0;
        cal_valid = '0;
        for (int i = 0; i < N_AXES; i++)
            cal_sum[i] = 0;
    endfunction

    function automatic void close_if_done(inout logic [W_STATUS-1:0] st);
        int limit_total;
        limit_total = RETRY_FACTOR * int'(cal_target);
        if (int'(cal_total) < limit_total && cal_valid < cal_target)
            return;
        cal_running = 1'b0;
        cal_final = (cal_valid < cal_min) ? ST_NOT_STILL : ST_OK;
        st = cal_final;
    endfunction

    // Mean of one axis in Q.4 counts, truncated toward zero
    function automatic logic signed [W_OFF-1:0] mean_q4(int axis);
        longint n, num, q;
        n   = longint'(cal_valid);
        num = cal_sum[axis] * 16;
        if (n == 0) begin
            q = (axis == 2 && cal_accel) ? -(longint'(cal_grav) * 16) : 0;
        end else begin
            if (axis == 2 && cal_accel)
                num = num - longint'(cal_grav) * 16 * n;
            q = num / n;
        end
        return q[W_OFF-1:0];
    endfunction

    function automatic t_report calib_step(t_sample it);
        t_report r;
        longint  s [N_AXES];
        longint  n, lim, d;
        bit      moved;
        r = '0;
        if (it.cmd == CMD_START) begin
            clear_run();
            if (cal_target < cal_min) begin
                cal_running = 1'b0;
                cal_final = ST_PARAM;
                r.status = ST_PARAM;
            end else begin
                cal_running = 1'b1;
                r.status = ST_COLLECT;
                close_if_done(r.status);
            end
        end else if (!cal_running) begin
            r.status = cal_final;
        end else begin
            s[0] = longint'(it.x);
            s[1] = longint'(it.y);
            s[2] = longint'(it.z);
            cal_total = cal_total + 1'b1;
            r.status = ST_COLLECT;
            if (cal_valid == 0) begin
                for (int i = 0; i < N_AXES; i++)
                    cal_sum[i] = s[i];
                cal_valid = 1;
            end else begin
                n = longint'(cal_valid);
                lim = longint'(cal_thr) * n;
                moved = 1'b0;
                for (int i = 0; i < N_AXES; i++) begin
                    d = s[i] * n - cal_sum[i];
                    if (d < 0)
                        d = -d;
                    if (d > lim)
                        moved = 1'b1;
                end
                if (moved) begin
                    clear_sums_only: for (int i = 0; i < N_AXES; i++)
                        cal_sum[i] = 0;
                    cal_valid = '0;
                    r.status = ST_MOTION;
                end else begin
                    for (int i = 0; i < N_AXES; i++)
                        cal_sum[i] = cal_sum[i] + s[i];
                    cal_valid = cal_valid + 1'b1;
                end
            end
            close_if_done(r.status);
        end
        if (r.status == ST_OK) begin
            r.off_x = mean_q4(0);
            r.off_y = mean_q4(1);
            r.off_z = mean_q4(2);
        end
        r.count = cal_valid;
        return r;
    endfunction

    function automatic int draw_wait();
        if ($urandom_range(0, 9) < 4)
            return 0;
        return $urandom_range(1, 16);
    endfunction

    // Driver: offer queued transactions, change inputs on the falling edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (tx_busy && in_acc_cnt != tx_seen) begin
                tx_seen = in_acc_cnt;
                tx_busy = 1'b0;
                tx_wait = snd_fast ? 0 : draw_wait();
            end
            if (!tx_busy) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (sample_q.size() > 0) begin
                    tx_cur = sample_q.pop_front();
                    tx_busy = 1'b1;
                end
            end
            in_valid <= tx_busy;
            in_cmd   <= tx_cur.cmd;
            in_x     <= tx_cur.x;
            in_y     <= tx_cur.y;
            in_z     <= tx_cur.z;
        end
    end

    // Receiver: random stall per result, plus a long hold when requested
    always @(negedge clk) begin
        if (hold_req != rx_hold_seen) begin
            rx_hold_seen = hold_req;
            rx_hold = HOLD_CYCLES;
        end
        if (res_cnt != rx_seen) begin
            rx_seen = res_cnt;
            rx_wait = rcv_fast ? 0 : draw_wait();
        end
        if (rx_hold > 0) begin
            rx_hold--;
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predict on each input transaction, check each result transaction
    always @(posedge clk) begin
        t_sample it;
        t_report want, got;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                it.cmd = in_cmd;
                it.x = in_x;
                it.y = in_y;
                it.z = in_z;
                due_reports.push_back(calib_step(it));
                in_acc_cnt++;
            end
            if (o_out_valid && !out_stall) begin
                got.status = o_status;
                got.off_x  = o_offset_x;
                got.off_y  = o_offset_y;
                got.off_z  = o_offset_z;
                got.count  = o_accepted_count;
                res_cnt++;
                if (due_reports.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN)
                        $display("%0t: unexpected result st=%0d x=%0d y=%0d z=%0d n=%0d",
                                 $realtime, got.status, got.off_x, got.off_y, got.off_z,
                                 got.count);
                end else begin
                    want = due_reports.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= MAX_SHOWN) begin
                            $write("%0t: mismatch exp st=%0d x=%0d y=%0d z=%0d n=%0d",
                                   $realtime, want.status, want.off_x, want.off_y,
                                   want.off_z, want.count);
                            $display(" got st=%0d x=%0d y=%0d z=%0d n=%0d", got.status,
                                     got.off_x, got.off_y, got.off_z, got.count);
                        end
                    end
                end
            end
        end
    end

    function automatic logic signed [W_SAMPLE-1:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[W_SAMPLE-1:0];
    endfunction

    function automatic int base_pick();
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int still_near(int base, int spread);
        int d;
        d = $urandom_range(0, spread);
        if ($urandom_range(0, 1))
            d = -d;
        return base + d;
    endfunction

    task automatic push_sample(logic cmd, int x, int y, int z);
        t_sample s;
        s.cmd = cmd;
        s.x = clamp16(x);
        s.y = clamp16(y);
        s.z = clamp16(z);
        sample_q.push_back(s);
        n_queued++;
    endtask

    task automatic push_start();
        push_sample(CMD_START, base_pick(), base_pick(), base_pick());
    endtask

    task automatic set_reg(logic [W_CFG_IDX-1:0] idx, int val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[W_CFG_DATA-1:0];
        case (idx)
            CFG_TARGET:    cal_target = val[W_CNT-1:0];
            CFG_MIN_VALID: cal_min    = val[W_CNT-1:0];
            CFG_THRESHOLD: cal_thr    = val[W_THR-1:0];
            CFG_AXIS_MODE: cal_accel  = val[0];
            CFG_GRAVITY:   cal_grav   = val[W_GRAV-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every queued transaction has gone in and every result come out
    task automatic drain();
        while (sample_q.size() != 0 || tx_busy || due_reports.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        int tgt, mv, thr, grav, pick, len, spread, bx, by, bz, ax, jump;
        for (int i = 0; i < N_AXES; i++)
            cal_sum[i] = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idle report, baseline at the extremes, motion restart
        push_sample(CMD_DATA, 1, 2, 3);
        push_start();
        push_sample(CMD_DATA, 32767, -32768, 0);
        push_sample(CMD_DATA, 32767, -32768, 0);
        push_sample(CMD_DATA, -32768, -32768, 0);
        drain();

        // zero target closes at once; the open run is discarded
        set_reg(CFG_TARGET, 0);
        set_reg(CFG_MIN_VALID, 0);
        push_start();
        push_sample(CMD_DATA, 100, -100, 7);
        drain();
        set_reg(CFG_AXIS_MODE, 1);
        set_reg(CFG_GRAVITY, 32767);
        push_sample(CMD_DATA, 5, 5, 5);
        push_start();
        drain();

        // target below the minimum
        set_reg(CFG_MIN_VALID, 1);
        push_start();
        push_sample(CMD_DATA, 0, 0, 0);
        drain();

        // zero threshold, still extremes, accel with no gravity
        set_reg(CFG_TARGET, 3);
        set_reg(CFG_MIN_VALID, 3);
        set_reg(CFG_THRESHOLD, 0);
        set_reg(CFG_GRAVITY, 0);
        push_start();
        repeat (3) push_sample(CMD_DATA, -32768, 32767, -32768);
        push_sample(CMD_DATA, 1, 1, 1);
        drain();

        // every second sample moves: run gives up after the retry limit
        set_reg(CFG_TARGET, 2);
        set_reg(CFG_MIN_VALID, 2);
        set_reg(CFG_AXIS_MODE, 0);
        push_start();
        repeat (3) begin
            push_sample(CMD_DATA, 0, 0, 0);
            push_sample(CMD_DATA, 0, 0, -1);
        end
        push_sample(CMD_DATA, 9, 9, 9);
        drain();

        // largest target and minimum, widest threshold
        set_reg(CFG_TARGET, 16383);
        set_reg(CFG_MIN_VALID, 16383);
        set_reg(CFG_THRESHOLD, 65535);
        set_reg(CFG_GRAVITY, 32767);
        push_start();
        push_sample(CMD_DATA, 32767, 32767, 32767);
        push_sample(CMD_DATA, -32768, -32768, -32768);
        drain();

        // long receiver hold while the sender keeps offering
        set_reg(CFG_TARGET, 30);
        set_reg(CFG_MIN_VALID, 5);
        set_reg(CFG_THRESHOLD, 100);
        snd_fast = 1'b1;
        hold_req++;
        bx = base_pick();
        by = base_pick();
        bz = base_pick();
        push_start();
        repeat (39) push_sample(CMD_DATA, still_near(bx, 40), still_near(by, 40),
                                still_near(bz, 40));
        drain();

        while (n_queued < N_RANDOM) begin
            snd_fast = ($urandom_range(0, 4) == 0);
            rcv_fast = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                tgt = $urandom_range(1, 24);
            else if (pick == 7)
                tgt = 0;
            else if (pick == 8)
                tgt = $urandom_range(25, 60);
            else
                tgt = 16383;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                mv = $urandom_range(0, tgt);
            else if (pick < 7)
                mv = 0;
            else if (pick < 9 || tgt == 16383)
                mv = tgt;
            else
                mv = $urandom_range(tgt + 1, 16383);
            pick = $urandom_range(0, 19);
            if (pick < 10)
                thr = $urandom_range(1, 200);
            else if (pick < 13)
                thr = 0;
            else if (pick < 15)
                thr = 65535;
            else
                thr = $urandom_range(0, 65535);
            pick = $urandom_range(0, 9);
            grav = (pick == 0) ? 0 : (pick == 1) ? 32767 : $urandom_range(0, 32767);
            set_reg(CFG_TARGET, tgt);
            set_reg(CFG_MIN_VALID, mv);
            set_reg(CFG_THRESHOLD, thr);
            set_reg(CFG_AXIS_MODE, $urandom_range(0, 1));
            set_reg(CFG_GRAVITY, grav);
            spread = (thr > 600) ? 300 : thr / 2;

            repeat ($urandom_range(1, 2)) begin
                // now and then carry on with the run left open before the writes
                if ($urandom_range(0, 9) != 0)
                    push_start();
                len = 3 * tgt + $urandom_range(0, 3);
                if (len > 80)
                    len = 80;
                bx = base_pick();
                by = base_pick();
                bz = base_pick();
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 7) begin
                        jump = thr + 1 + $urandom_range(0, 500);
                        if ($urandom_range(0, 1))
                            jump = -jump;
                        ax = $urandom_range(0, 2);
                        push_sample(CMD_DATA, bx + ((ax == 0) ? jump : 0),
                                    by + ((ax == 1) ? jump : 0),
                                    bz + ((ax == 2) ? jump : 0));
                    end else if (pick < 9) begin
                        push_start();
                    end else if (pick < 12) begin
                        push_sample(CMD_DATA, base_pick(), base_pick(), base_pick());
                    end else begin
                        push_sample(CMD_DATA, still_near(bx, spread),
                                    still_near(by, spread), still_near(bz, spread));
                    end
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_bad == 0 && due_reports.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
